// ----- hdl/hkr_pkg.sv -----
// ---------------------------------------------------------------------------
// hkr_pkg
// Shared types, codes and the fixed code translation table of the HID
// key remapper.
// ---------------------------------------------------------------------------
package hkr_pkg;

    // report bytes carried on the input side
    localparam int C_CARRIED_BYTES    = 8;
    // longest report length taken at face value
    localparam int C_MAX_REPORT_BYTES = 8;
    // keycode slots of a keyboard report (bytes 2 to 7)
    localparam int C_KEY_SLOTS        = 6;
    localparam int C_KEY_FIRST_BYTE   = 2;

    // incoming report ids
    localparam logic [7:0] C_ID_IN_CONSUMER = 8'd1;
    localparam logic [7:0] C_ID_IN_KEYBOARD = 8'd11;

    // outgoing report kinds
    localparam logic [1:0] C_CH_CONSUMER = 2'd1;
    localparam logic [1:0] C_CH_KEYBOARD = 2'd2;

    typedef struct packed {
        logic        hit;
        logic [1:0]  ch;
        logic [15:0] code;
    } t_map_hit;

    // translate one incoming code, a miss returns hit = 0
    function automatic t_map_hit map_lookup(input logic [7:0] id, input logic [15:0] code);
        t_map_hit r;
        r.hit  = 1'b1;
        r.ch   = C_CH_KEYBOARD;
        r.code = 16'h0000;
        case ({id, code})
            {C_ID_IN_CONSUMER, 16'h00E2}: begin r.ch = C_CH_CONSUMER; r.code = 16'h00E2; end
            {C_ID_IN_CONSUMER, 16'h0221}: begin r.ch = C_CH_CONSUMER; r.code = 16'h0221; end
            {C_ID_IN_CONSUMER, 16'h0042}: r.code = 16'h0052;
            {C_ID_IN_CONSUMER, 16'h0043}: r.code = 16'h0051;
            {C_ID_IN_CONSUMER, 16'h0044}: r.code = 16'h0050;
            {C_ID_IN_CONSUMER, 16'h0045}: r.code = 16'h004F;
            {C_ID_IN_CONSUMER, 16'h0041}: r.code = 16'h0028;
            {C_ID_IN_CONSUMER, 16'h0224}: r.code = 16'h0029;
            {C_ID_IN_CONSUMER, 16'h0223}: r.code = 16'h0005;
            {C_ID_IN_CONSUMER, 16'h009C}: r.code = 16'h004B;
            {C_ID_IN_CONSUMER, 16'h009D}: r.code = 16'h004E;
            {C_ID_IN_CONSUMER, 16'h0030}: r.code = 16'h0068;
            {C_ID_IN_CONSUMER, 16'h019C}: r.code = 16'h0069;
            {C_ID_IN_CONSUMER, 16'h01BB}: r.code = 16'h006A;
            {C_ID_IN_CONSUMER, 16'h009F}: r.code = 16'h006B;
            {C_ID_IN_CONSUMER, 16'h008D}: r.code = 16'h003E;
            {C_ID_IN_CONSUMER, 16'h0077}: r.code = 16'h006D;
            {C_ID_IN_CONSUMER, 16'h0078}: r.code = 16'h006E;
            {C_ID_IN_CONSUMER, 16'h0079}: r.code = 16'h006F;
            {C_ID_IN_CONSUMER, 16'h007A}: r.code = 16'h0070;
            {C_ID_IN_KEYBOARD, 16'h0080}: begin r.ch = C_CH_CONSUMER; r.code = 16'h00E9; end
            {C_ID_IN_KEYBOARD, 16'h0081}: begin r.ch = C_CH_CONSUMER; r.code = 16'h00EA; end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/hid_key_remap.sv -----
// ---------------------------------------------------------------------------
// hid_key_remap
// Turns incoming HID reports into press/release results on an outgoing
// consumer-control or keyboard channel, through a fixed translation table.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  report   | i_valid / o_ready  | i_report_id, i_report_length, i_byte_0..7
//  result   | o_valid / i_ready  | o_usb_report_id, o_usage_code, o_pressed,
//           |                    | o_last
//
//  a report passes from the input register into the hit register, which holds
//  its table hits (up to six); these are played out through the output
//  register one result per cycle while the result side does not stall, each
//  hit as a press and then a release. reset clears all valid flags and the
//  pending hit mask. a stall on the result side holds the output register;
//  the hit register and the input register then fill up and o_ready drops.
// ---------------------------------------------------------------------------
module hid_key_remap import hkr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // report channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_report_id,
    input  logic [3:0]  i_report_length,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_usb_report_id,
    output logic [15:0] o_usage_code,
    output logic        o_pressed,
    output logic        o_last
);

    // ---- input register ---------------------------------------------------
    logic                             r_in_valid;
    logic [7:0]                       r_in_id;
    logic [3:0]                       r_in_len;
    logic [C_CARRIED_BYTES-1:0][7:0]  r_in_byte;

    // ---- hit register: one slot per keycode position ----------------------
    logic [C_KEY_SLOTS-1:0]           r_pend, n_pend;
    logic [C_KEY_SLOTS-1:0][1:0]      r_ch;
    logic [C_KEY_SLOTS-1:0][15:0]     r_code;
    logic                             r_phase, n_phase;   // 0 press, 1 release

    // ---- output register --------------------------------------------------
    logic        r_out_valid;
    logic [1:0]  r_out_ch;
    logic [15:0] r_out_code;
    logic        r_out_pressed;
    logic        r_out_last;

    // decode results
    logic [3:0]                   len_sat;
    logic                         any_nz;
    logic [C_KEY_SLOTS-1:0]       dec_mask;
    logic [C_KEY_SLOTS-1:0][1:0]  dec_ch;
    logic [C_KEY_SLOTS-1:0][15:0] dec_code;
    t_map_hit                     lk;

    // emitter control
    logic                   out_load;   // output register can take a result
    logic                   emit;       // a result moves into the output register
    logic [C_KEY_SLOTS-1:0] sel_oh;     // lowest pending slot
    logic [2:0]             sel_idx;
    logic [C_KEY_SLOTS-1:0] remain;     // pending slots once the current one ends
    logic                   hit_free;   // hit register takes a new report next edge
    logic                   hit_load;

    // ---- decode of the report in the input register -----------------------
    always_comb begin
        len_sat  = (r_in_len > 4'(C_MAX_REPORT_BYTES)) ? 4'(C_MAX_REPORT_BYTES) : r_in_len;
        any_nz   = 1'b0;
        dec_mask = '0;
        dec_ch   = '0;
        dec_code = '0;
        lk       = '0;
        // all-zero valid bytes mean a release report
        for (int i = 0; i < C_CARRIED_BYTES; i++) begin
            if ((4'(i) < len_sat) && (r_in_byte[i] != 8'h00)) begin
                any_nz = 1'b1;
            end
        end
        if (any_nz && (r_in_id == C_ID_IN_CONSUMER) && (len_sat >= 4'd2)) begin
            // 16-bit consumer usage, low byte first, goes in slot 0
            lk          = map_lookup(C_ID_IN_CONSUMER, {r_in_byte[1], r_in_byte[0]});
            dec_mask[0] = lk.hit;
            dec_ch[0]   = lk.ch;
            dec_code[0] = lk.code;
        end else if (any_nz && (r_in_id == C_ID_IN_KEYBOARD)
                     && (len_sat >= 4'(C_CARRIED_BYTES))) begin
            // six keycode slots looked up side by side, zero slots skipped
            for (int s = 0; s < C_KEY_SLOTS; s++) begin
                lk          = map_lookup(C_ID_IN_KEYBOARD,
                                         {8'h00, r_in_byte[s + C_KEY_FIRST_BYTE]});
                dec_mask[s] = lk.hit && (r_in_byte[s + C_KEY_FIRST_BYTE] != 8'h00);
                dec_ch[s]   = lk.ch;
                dec_code[s] = lk.code;
            end
        end
    end

    // ---- emitter: lowest pending slot, press then release -----------------
    always_comb begin
        sel_oh  = '0;
        sel_idx = '0;
        for (int s = C_KEY_SLOTS - 1; s >= 0; s--) begin
            if (r_pend[s]) begin
                sel_oh  = '0;
                sel_oh[s] = 1'b1;
                sel_idx = 3'(s);
            end
        end
        remain   = r_pend & ~sel_oh;
        out_load = !r_out_valid || i_ready;
        emit     = out_load && (r_pend != '0);
        hit_free = (r_pend == '0) || (emit && r_phase && (remain == '0));
        hit_load = r_in_valid && hit_free;
        o_ready  = !r_in_valid || hit_free;

        n_pend  = r_pend;
        n_phase = r_phase;
        if (emit) begin
            if (r_phase) begin
                n_pend  = remain;
                n_phase = 1'b0;
            end else begin
                n_phase = 1'b1;
            end
        end
        if (hit_load) begin
            n_pend  = dec_mask;
            n_phase = 1'b0;
        end
    end

    // ---- control registers ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pend      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_pend  <= n_pend;
            r_phase <= n_phase;
            if (out_load) begin
                r_out_valid <= emit;
            end
        end
    end

    // ---- payload registers ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_id      <= i_report_id;
            r_in_len     <= i_report_length;
            r_in_byte[0] <= i_byte_0;
            r_in_byte[1] <= i_byte_1;
            r_in_byte[2] <= i_byte_2;
            r_in_byte[3] <= i_byte_3;
            r_in_byte[4] <= i_byte_4;
            r_in_byte[5] <= i_byte_5;
            r_in_byte[6] <= i_byte_6;
            r_in_byte[7] <= i_byte_7;
        end
        if (hit_load) begin
            r_ch   <= dec_ch;
            r_code <= dec_code;
        end
        if (emit) begin
            // release repeats the channel of its press with a zero code
            r_out_ch      <= r_ch[sel_idx];
            r_out_code    <= r_phase ? 16'h0000 : r_code[sel_idx];
            r_out_pressed <= !r_phase;
            r_out_last    <= r_phase && (remain == '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_usb_report_id = r_out_ch;
    assign o_usage_code    = r_out_code;
    assign o_pressed       = r_out_pressed;
    assign o_last          = r_out_last;

    // ---- checks -----------------------------------------------------------
    a_phase_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_pend != '0))
        else $error("release phase with no pending slot");

    a_last_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !o_pressed)
        else $error("last result is not a release");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pressed) |-> (o_usage_code == 16'h0000))
        else $error("release carries a nonzero code");

    a_release_follows_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !r_phase) |=> (r_out_valid && r_out_pressed && r_phase))
        else $error("press not followed by release phase");

    a_channel_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_usb_report_id == C_CH_CONSUMER)
                     || (o_usb_report_id == C_CH_KEYBOARD)))
        else $error("unknown outgoing report kind");

endmodule

// ----- sim/hkr_checker.sv -----
// ---------------------------------------------------------------------------
// hkr_checker
// Watches both channels of the HID key remapper, works out the press and
// release results of every accepted report and compares them in order with
// the results that leave the block.
// ---------------------------------------------------------------------------
module hkr_checker import hkr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // report channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_report_id,
    input  logic [3:0]  i_report_length,
    input  logic [63:0] i_report_bytes,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_usb_report_id,
    input  logic [15:0] i_usage_code,
    input  logic        i_pressed,
    input  logic        i_last,
    // status
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REMAP_ENTRIES = 22;

    typedef struct packed {
        logic [7:0]  src_id;
        logic [15:0] src_code;
        logic [1:0]  ch;
        logic [15:0] code;
    } t_remap_entry;

    typedef struct packed {
        logic [1:0]  ch;
        logic [15:0] code;
        logic        pressed;
        logic        last;
    } t_key_event;

    t_key_event expected_events[$];
    int         fails = 0;

    function automatic t_remap_entry remap_entry(input int idx);
        case (idx)
            0:  return '{C_ID_IN_CONSUMER, 16'h00E2, C_CH_CONSUMER, 16'h00E2};
            1:  return '{C_ID_IN_CONSUMER, 16'h0221, C_CH_CONSUMER, 16'h0221};
            2:  return '{C_ID_IN_CONSUMER, 16'h0042, C_CH_KEYBOARD, 16'h0052};
            3:  return '{C_ID_IN_CONSUMER, 16'h0043, C_CH_KEYBOARD, 16'h0051};
            4:  return '{C_ID_IN_CONSUMER, 16'h0044, C_CH_KEYBOARD, 16'h0050};
            5:  return '{C_ID_IN_CONSUMER, 16'h0045, C_CH_KEYBOARD, 16'h004F};
            6:  return '{C_ID_IN_CONSUMER, 16'h0041, C_CH_KEYBOARD, 16'h0028};
            7:  return '{C_ID_IN_CONSUMER, 16'h0224, C_CH_KEYBOARD, 16'h0029};
            8:  return '{C_ID_IN_CONSUMER, 16'h0223, C_CH_KEYBOARD, 16'h0005};
            9:  return '{C_ID_IN_CONSUMER, 16'h009C, C_CH_KEYBOARD, 16'h004B};
            10: return '{C_ID_IN_CONSUMER, 16'h009D, C_CH_KEYBOARD, 16'h004E};
            11: return '{C_ID_IN_CONSUMER, 16'h0030, C_CH_KEYBOARD, 16'h0068};
            12: return '{C_ID_IN_CONSUMER, 16'h019C, C_CH_KEYBOARD, 16'h0069};
            13: return '{C_ID_IN_CONSUMER, 16'h01BB, C_CH_KEYBOARD, 16'h006A};
            14: return '{C_ID_IN_CONSUMER, 16'h009F, C_CH_KEYBOARD, 16'h006B};
            15: return '{C_ID_IN_CONSUMER, 16'h008D, C_CH_KEYBOARD, 16'h003E};
            16: return '{C_ID_IN_CONSUMER, 16'h0077, C_CH_KEYBOARD, 16'h006D};
            17: return '{C_ID_IN_CONSUMER, 16'h0078, C_CH_KEYBOARD, 16'h006E};
            18: return '{C_ID_IN_CONSUMER, 16'h0079, C_CH_KEYBOARD, 16'h006F};
            19: return '{C_ID_IN_CONSUMER, 16'h007A, C_CH_KEYBOARD, 16'h0070};
            20: return '{C_ID_IN_KEYBOARD, 16'h0080, C_CH_CONSUMER, 16'h00E9};
            21: return '{C_ID_IN_KEYBOARD, 16'h0081, C_CH_CONSUMER, 16'h00EA};
            default: return '0;
        endcase
    endfunction

    // index of the matching entry, -1 on a miss
    function automatic int find_remap(input logic [7:0] id, input logic [15:0] code);
        t_remap_entry e;
        for (int k = 0; k < REMAP_ENTRIES; k++) begin
            e = remap_entry(k);
            if (e.src_id == id && e.src_code == code)
                return k;
        end
        return -1;
    endfunction

    task automatic predict_remap(input logic [7:0] id, input logic [3:0] length,
                                 input logic [63:0] data);
        int           valid_len;
        int           hits [C_KEY_SLOTS];
        int           n_hits;
        int           idx;
        bit           all_clear;
        t_remap_entry e;
        valid_len = (length > C_MAX_REPORT_BYTES) ? C_MAX_REPORT_BYTES : int'(length);
        all_clear = 1'b1;
        for (int k = 0; k < valid_len && k < C_CARRIED_BYTES; k++)
            if (data[8*k +: 8] != 8'h00)
                all_clear = 1'b0;
        n_hits = 0;
        if (!all_clear) begin
            if (id == C_ID_IN_CONSUMER && valid_len >= 2) begin
                idx = find_remap(id, data[15:0]);
                if (idx >= 0) begin
                    hits[0] = idx;
                    n_hits  = 1;
                end
            end else if (id == C_ID_IN_KEYBOARD && valid_len >= C_MAX_REPORT_BYTES) begin
                // slots scanned in order, empty slots skipped
                for (int k = C_KEY_FIRST_BYTE; k < C_CARRIED_BYTES; k++) begin
                    if (data[8*k +: 8] != 8'h00) begin
                        idx = find_remap(id, {8'h00, data[8*k +: 8]});
                        if (idx >= 0) begin
                            hits[n_hits] = idx;
                            n_hits++;
                        end
                    end
                end
            end
        end
        for (int h = 0; h < n_hits; h++) begin
            e = remap_entry(hits[h]);
            expected_events.push_back('{e.ch, e.code, 1'b1, 1'b0});
            expected_events.push_back('{e.ch, 16'h0000, 1'b0, (h == n_hits - 1)});
        end
    endtask

    task automatic check_event();
        t_key_event want;
        if (expected_events.size() == 0) begin
            $display("%0t: unexpected result ch=%0d code=%h pressed=%b last=%b",
                     $time, i_usb_report_id, i_usage_code, i_pressed, i_last);
            fails++;
        end else begin
            want = expected_events.pop_front();
            if (i_usb_report_id !== want.ch) begin
                $display("%0t: usb_report_id expected %0d actual %0d",
                         $time, want.ch, i_usb_report_id);
                fails++;
            end
            if (i_usage_code !== want.code) begin
                $display("%0t: usage_code expected %h actual %h",
                         $time, want.code, i_usage_code);
                fails++;
            end
            if (i_pressed !== want.pressed) begin
                $display("%0t: pressed expected %b actual %b",
                         $time, want.pressed, i_pressed);
                fails++;
            end
            if (i_last !== want.last) begin
                $display("%0t: last expected %b actual %b",
                         $time, want.last, i_last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready)
                check_event();
            if (i_in_valid && i_in_ready)
                predict_remap(i_report_id, i_report_length, i_report_bytes);
        end
        o_fail_count <= fails;
        o_pending    <= expected_events.size();
    end

endmodule

// ----- sim/hid_key_remap_test.sv -----
// ---------------------------------------------------------------------------
// hid_key_remap_test
// Drives HID reports into the key remapper under changing sender and
// receiver pacing and leaves result checking to hkr_checker.
// ---------------------------------------------------------------------------
module hid_key_remap_test import hkr_pkg::*;;

    // cycles with no transfer on either channel before giving up
    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 60;
    // quiet cycles after the last expected result, to catch stray results
    localparam int DRAIN_CYCLES    = 20;
    // incoming consumer usages that the table knows
    localparam logic [20*16-1:0] CONSUMER_CODES = {
        16'h00E2, 16'h0221, 16'h0042, 16'h0043, 16'h0044,
        16'h0045, 16'h0041, 16'h0224, 16'h0223, 16'h009C,
        16'h009D, 16'h0030, 16'h019C, 16'h01BB, 16'h009F,
        16'h008D, 16'h0077, 16'h0078, 16'h0079, 16'h007A
    };

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic [7:0]  i_report_id     = '0;
    logic [3:0]  i_report_length = '0;
    logic [7:0]  i_byte_0        = '0;
    logic [7:0]  i_byte_1        = '0;
    logic [7:0]  i_byte_2        = '0;
    logic [7:0]  i_byte_3        = '0;
    logic [7:0]  i_byte_4        = '0;
    logic [7:0]  i_byte_5        = '0;
    logic [7:0]  i_byte_6        = '0;
    logic [7:0]  i_byte_7        = '0;
    logic        o_valid;
    logic        i_ready         = 1'b1;
    logic [1:0]  o_usb_report_id;
    logic [15:0] o_usage_code;
    logic        o_pressed;
    logic        o_last;

    int fail_count;
    int pending_results;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int quiet_cycles    = 0;

    hid_key_remap dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_report_id     (i_report_id),
        .i_report_length (i_report_length),
        .i_byte_0        (i_byte_0),
        .i_byte_1        (i_byte_1),
        .i_byte_2        (i_byte_2),
        .i_byte_3        (i_byte_3),
        .i_byte_4        (i_byte_4),
        .i_byte_5        (i_byte_5),
        .i_byte_6        (i_byte_6),
        .i_byte_7        (i_byte_7),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_usb_report_id (o_usb_report_id),
        .o_usage_code    (o_usage_code),
        .o_pressed       (o_pressed),
        .o_last          (o_last)
    );

    // checker sits beside the block and only watches its ports
    hkr_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_report_id     (i_report_id),
        .i_report_length (i_report_length),
        .i_report_bytes  ({i_byte_7, i_byte_6, i_byte_5, i_byte_4,
                           i_byte_3, i_byte_2, i_byte_1, i_byte_0}),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_usb_report_id (o_usb_report_id),
        .i_usage_code    (o_usage_code),
        .i_pressed       (o_pressed),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: a fresh stall decision every cycle
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    // watchdog: a hang shows up as a long run of cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one report transfer; byte n of the report sits in data[8n+7:8n]
    // valid is only lowered when the sender idles, so back-to-back reports
    // keep it high across the edge
    task automatic send_report(input logic [7:0] id, input logic [3:0] length,
                               input logic [63:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_report_id     <= id;
        i_report_length <= length;
        {i_byte_7, i_byte_6, i_byte_5, i_byte_4,
         i_byte_3, i_byte_2, i_byte_1, i_byte_0} <= data;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // mostly well-formed consumer and keyboard reports with random content,
    // the rest noise; noise reports are not counted toward the phase
    task automatic send_random_report(output bit counted);
        logic [7:0]  id;
        logic [3:0]  length;
        logic [63:0] data;
        int          pick;
        int          slot_kind;
        int          code_idx;
        pick    = $urandom_range(99);
        data    = {$urandom, $urandom};
        counted = 1'b1;
        if (pick < 45) begin
            id = C_ID_IN_CONSUMER;
            // lengths past eight are saturated by the block
            length = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8, 2));
            if ($urandom_range(9) < 8) begin
                code_idx   = $urandom_range(19);
                data[15:0] = CONSUMER_CODES[16*code_idx +: 16];
            end
        end else if (pick < 85) begin
            id     = C_ID_IN_KEYBOARD;
            length = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
            for (int k = C_KEY_FIRST_BYTE; k < C_CARRIED_BYTES; k++) begin
                slot_kind = $urandom_range(9);
                if (slot_kind < 4)
                    data[8*k +: 8] = 8'h00;
                else if (slot_kind < 8)
                    data[8*k +: 8] = 8'h80 | 8'($urandom_range(1));
            end
        end else begin
            counted = 1'b0;
            case ($urandom_range(2))
                0:       id = C_ID_IN_CONSUMER;
                1:       id = C_ID_IN_KEYBOARD;
                default: id = 8'($urandom);
            endcase
            length = 4'($urandom_range(15));
            if ($urandom_range(3) == 0)
                data = '0;
        end
        send_report(id, length, data);
    endtask

    initial begin
        int counted_items;
        bit counted;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed reports, no idling on either side
        // table hits on the consumer id, short and full lengths
        send_report(C_ID_IN_CONSUMER, 4'd2, 64'h0000_0000_0000_00E2);
        send_report(C_ID_IN_CONSUMER, 4'd8, 64'hFFFF_FFFF_FFFF_0221);
        send_report(C_ID_IN_CONSUMER, 4'd3, 64'h0000_0000_00AA_0042);
        send_report(C_ID_IN_CONSUMER, 4'd8, 64'h0102_0304_0506_007A);
        // length past eight saturates
        send_report(C_ID_IN_CONSUMER, 4'd15, 64'h0000_0000_0000_0224);
        send_report(C_ID_IN_CONSUMER, 4'd9, 64'h8080_8080_8080_0045);
        // release report, all zero
        send_report(C_ID_IN_CONSUMER, 4'd8, 64'h0);
        // empty report, bytes present but length zero
        send_report(C_ID_IN_CONSUMER, 4'd0, 64'h0000_0000_0000_00E2);
        // short consumer report
        send_report(C_ID_IN_CONSUMER, 4'd1, 64'h0000_0000_0000_00E2);
        // valid bytes zero, data only beyond the length
        send_report(C_ID_IN_CONSUMER, 4'd2, 64'hFFFF_FFFF_FFFF_0000);
        // misses: unknown usage, keyboard code on the consumer id
        send_report(C_ID_IN_CONSUMER, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_report(C_ID_IN_CONSUMER, 4'd2, 64'h0000_0000_0000_0080);
        // keyboard report with every slot a hit: twelve results
        send_report(C_ID_IN_KEYBOARD, 4'd8,
                    {8'h81, 8'h80, 8'h81, 8'h80, 8'h81, 8'h80, 16'h0000});
        // empty slots and misses mixed in
        send_report(C_ID_IN_KEYBOARD, 4'd8,
                    {8'h00, 8'h81, 8'hFF, 8'h00, 8'h80, 8'h7F, 16'hFFFF});
        // long keyboard report, single hit in the last slot
        send_report(C_ID_IN_KEYBOARD, 4'd15, {8'h80, 40'h0, 16'h0000});
        // short keyboard report
        send_report(C_ID_IN_KEYBOARD, 4'd7,
                    {8'h81, 8'h80, 8'h81, 8'h80, 8'h81, 8'h80, 16'h0000});
        // keyboard with data only in the modifier bytes
        send_report(C_ID_IN_KEYBOARD, 4'd8, 64'h0000_0000_0000_0102);
        // keyboard release
        send_report(C_ID_IN_KEYBOARD, 4'd8, 64'h0);
        // other report ids
        send_report(8'd0, 4'd2, 64'h0000_0000_0000_00E2);
        send_report(8'd2, 4'd8, {8'h81, 8'h80, 8'h81, 8'h80, 8'h81, 8'h80, 16'h00E2});
        send_report(8'd255, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct      <= 0;
                end
                1: begin
                    sender_idle_pct = 83;
                    stall_pct      <= 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct      <= 83;
                end
                default: begin
                    sender_idle_pct = 37;
                    stall_pct      <= 37;
                end
            endcase
            counted_items = 0;
            while (counted_items < ITEMS_PER_PHASE) begin
                send_random_report(counted);
                if (counted)
                    counted_items++;
            end
        end

        i_valid <= 1'b0;
        // the checker's pending count is registered and trails its queue
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- hid_key_remap.f -----
hdl/hkr_pkg.sv
hdl/hid_key_remap.sv
sim/hkr_checker.sv
sim/hid_key_remap_test.sv
